// ===== rtl/core/ita_pkg.sv =====
package ita_pkg;

	localparam int MAX_FIELD_WIDTH_DEF = 32;

	// digit store: 32-bit octal is the longest case at 11 digits
	localparam int DIG_MAX    = 12;
	localparam int DIG_CNT_W  = 4;
	localparam int TEXT_LEN_W = 4;

	localparam logic [1:0] BASE_OCT = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam int FLAG_LEFT    = 0;
	localparam int FLAG_SIGN    = 1;
	localparam int FLAG_SPACE   = 2;
	localparam int FLAG_PREFIX  = 3;
	localparam int FLAG_ZERO    = 4;
	localparam int FLAG_SIGNINT = 5;

	// x / 10 == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
	localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
	localparam int          DEC_SHIFT = 35;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_A_OFS = 8'h57;	// 'a' - 10

	typedef struct packed {
		logic        start;
		logic [1:0]  base_sel;
		logic [31:0] operand;
	} du_req_t;

	typedef struct packed {
		logic        done;
		logic [3:0]  digit;
		logic [31:0] quot;
	} du_rsp_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'h0, d};
		end else begin
			c = CH_A_OFS + {4'h0, d};
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/ita_digit_unit.sv =====
module ita_digit_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  ita_pkg::du_req_t req,
	output ita_pkg::du_rsp_t rsp
);
	import ita_pkg::*;

	logic        busy_q;
	logic [1:0]  base_q;
	logic [31:0] op_q;
	logic [63:0] prod_q;

	logic        is_dec;
	logic [31:0] q_dec;
	logic [31:0] q10;
	logic [3:0]  r_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= req.start;
		end
	end

	// on a start request: capture operand and reciprocal product
	always_ff @(posedge clk) begin
		if (req.start) begin
			base_q <= req.base_sel;
			op_q   <= req.operand;
			prod_q <= 64'(req.operand) * 64'(DEC_RECIP);
		end
	end

	// from the registered operand and product: quotient, remainder by shift-add
	assign is_dec = (base_q != BASE_OCT) && (base_q != BASE_HEX);
	assign q_dec  = 32'(prod_q[63:DEC_SHIFT]);
	assign q10    = (q_dec << 3) + (q_dec << 1);
	assign r_dec  = op_q[3:0] - q10[3:0];

	always_comb begin
		rsp.done = busy_q;
		case (base_q)
			BASE_OCT: begin
				rsp.digit = {1'b0, op_q[2:0]};
				rsp.quot  = op_q >> 3;
			end
			BASE_HEX: begin
				rsp.digit = op_q[3:0];
				rsp.quot  = op_q >> 4;
			end
			default: begin
				rsp.digit = r_dec;
				rsp.quot  = q_dec;
			end
		endcase
	end

	a_dec_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && is_dec) |-> (r_dec < 4'd10))
		else $error("decimal digit out of range");

	a_dec_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && is_dec) |-> ((q10 + 32'(r_dec)) == op_q))
		else $error("decimal quotient and remainder do not rebuild operand");

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// Integer to ASCII field formatter.
// Input channel (in_valid / in_stall): one item carries value, field_width,
// base_select (0 octal, 1 decimal, 2 hex, 3 as decimal) and style_flags
// (bit0 left, bit1 sign, bit2 space, bit3 prefix, bit4 zero fill,
// bit5 signed int). Output channel (out_valid / out_stall): one character
// per item in out_char, last set on the final character of the field.
// The block works on one item at a time and holds in_stall high from the
// accept until its final character has been loaded into the output register.
// Digits come from one shared digit unit at one per cycle; each quotient is fed
// straight back as the next operand. Characters then leave at one per cycle while
// the output is not stalled; each absent part of the field (leading fill, '0',
// 'x', sign) is passed over in its own state without loading a character.
// The first character is loaded only after the last digit has been produced.
// A stalled output register holds its character; emission simply waits.
// The next item can be accepted while the final character is still stalled.
// Reset (arst_n low) returns to idle and drops out_valid; no item is lost
// other than one in flight at the time of reset.
module integer_to_ascii_formatter #(
	parameter int MAX_FIELD_WIDTH = ita_pkg::MAX_FIELD_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	input  logic [5:0]  field_width,
	input  logic [1:0]  base_select,
	input  logic [5:0]  style_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        last
);
	import ita_pkg::*;

	localparam int WW = $clog2(MAX_FIELD_WIDTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;
	typedef enum logic [2:0] {P_LPAD, P_PFX0, P_PFXX, P_SIGN, P_DIG, P_RPAD} phase_t;

	state_t               state_q;
	phase_t               phase_q;
	logic [DIG_CNT_W-1:0] ndig_q;
	logic [WW-1:0]        wid_q;
	logic [WW-1:0]        pad_q;
	logic [1:0]           base_q;
	logic                 left_q;
	logic [7:0]           fill_q;
	logic [1:0]           nprefix_q;
	logic                 has_sign_q;
	logic [7:0]           sign_q;
	logic                 out_valid_q;
	logic [7:0]           out_char_q;
	logic                 last_q;
	logic [3:0]           digits_q [DIG_MAX];

	du_req_t du_req;
	du_rsp_t du_rsp;

	logic                  accept;
	logic                  is_dec;
	logic [31:0]           num_in;
	logic                  has_sign_in;
	logic [7:0]            sign_in;
	logic [1:0]            nprefix_in;
	logic [WW-1:0]         wid_in;
	logic                  conv_done;
	logic                  conv_more;
	logic [TEXT_LEN_W-1:0] text_len;
	logic [WW-1:0]         pad_new;
	logic                  out_free;
	logic [3:0]            dig_rd;
	logic                  emit;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign is_dec   = (base_select != BASE_OCT) && (base_select != BASE_HEX);

	always_comb begin
		num_in      = value;
		has_sign_in = 1'b0;
		sign_in     = CH_SPACE;
		if (style_flags[FLAG_SIGN] && is_dec) begin
			if (value[31]) begin
				has_sign_in = 1'b1;
				sign_in     = CH_MINUS;
				num_in      = 32'd0 - value;
			end else if (!style_flags[FLAG_SIGNINT]) begin
				has_sign_in = 1'b1;
				sign_in     = CH_PLUS;
			end
		end else if (!style_flags[FLAG_SIGN] && !value[31] && is_dec &&
		             style_flags[FLAG_SPACE]) begin
			has_sign_in = 1'b1;
			sign_in     = CH_SPACE;
		end
	end

	always_comb begin
		nprefix_in = 2'd0;
		if (style_flags[FLAG_PREFIX]) begin
			if (base_select == BASE_HEX) begin
				nprefix_in = 2'd2;
			end else if (base_select == BASE_OCT) begin
				nprefix_in = 2'd1;
			end
		end
	end

	always_comb begin
		if ({1'b0, field_width} > 7'(MAX_FIELD_WIDTH)) begin
			wid_in = WW'(MAX_FIELD_WIDTH);
		end else begin
			wid_in = WW'(field_width);
		end
	end

	// keep dividing until the quotient runs out; a zero value still gives one digit
	assign conv_done = (state_q == S_CONV) && du_rsp.done;
	assign conv_more = conv_done && (du_rsp.quot != 32'd0);

	assign du_req.start    = accept || conv_more;
	assign du_req.base_sel = accept ? base_select : base_q;
	assign du_req.operand  = accept ? num_in : du_rsp.quot;

	ita_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (du_req),
		.rsp    (du_rsp)
	);

	assign text_len = TEXT_LEN_W'(nprefix_q) + TEXT_LEN_W'(has_sign_q) + ndig_q + 4'd1;
	assign pad_new  = (wid_q > WW'(text_len)) ? (wid_q - WW'(text_len)) : '0;

	assign out_free = !out_valid_q || !out_stall;
	assign dig_rd   = digits_q[ndig_q - 4'd1];

	// a character is loaded this cycle
	always_comb begin
		emit = 1'b0;
		if (state_q == S_EMIT && out_free) begin
			unique case (phase_q)
				P_LPAD:  emit = !left_q && (pad_q != '0);
				P_PFX0:  emit = (nprefix_q != 2'd0);
				P_PFXX:  emit = (nprefix_q == 2'd2);
				P_SIGN:  emit = has_sign_q;
				P_DIG:   emit = 1'b1;
				P_RPAD:  emit = 1'b1;
				default: emit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (conv_done) begin
			digits_q[ndig_q] <= du_rsp.digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= P_LPAD;
			ndig_q      <= '0;
			wid_q       <= '0;
			pad_q       <= '0;
			base_q      <= BASE_OCT;
			left_q      <= 1'b0;
			fill_q      <= CH_SPACE;
			nprefix_q   <= 2'd0;
			has_sign_q  <= 1'b0;
			sign_q      <= CH_SPACE;
			out_valid_q <= 1'b0;
			out_char_q  <= CH_SPACE;
			last_q      <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_CONV;
						phase_q    <= P_LPAD;
						ndig_q     <= '0;
						wid_q      <= wid_in;
						base_q     <= base_select;
						left_q     <= style_flags[FLAG_LEFT];
						fill_q     <= style_flags[FLAG_ZERO] ? CH_ZERO : CH_SPACE;
						nprefix_q  <= nprefix_in;
						has_sign_q <= has_sign_in;
						sign_q     <= sign_in;
					end
				end
				S_CONV: begin
					if (conv_done) begin
						ndig_q <= ndig_q + 4'd1;
						if (!conv_more) begin
							pad_q   <= pad_new;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					unique case (phase_q)
						P_LPAD: begin
							if (!left_q && pad_q != '0) begin
								if (out_free) begin
									out_char_q  <= fill_q;
									last_q      <= 1'b0;
									pad_q       <= pad_q - 1'b1;
									if (pad_q == WW'(1)) begin
										phase_q <= P_PFX0;
									end
								end
							end else begin
								phase_q <= P_PFX0;
							end
						end
						P_PFX0: begin
							if (nprefix_q != 2'd0) begin
								if (out_free) begin
									out_char_q  <= CH_ZERO;
									last_q      <= 1'b0;
									phase_q     <= P_PFXX;
								end
							end else begin
								phase_q <= P_PFXX;
							end
						end
						P_PFXX: begin
							if (nprefix_q == 2'd2) begin
								if (out_free) begin
									out_char_q  <= CH_X;
									last_q      <= 1'b0;
									phase_q     <= P_SIGN;
								end
							end else begin
								phase_q <= P_SIGN;
							end
						end
						P_SIGN: begin
							if (has_sign_q) begin
								if (out_free) begin
									out_char_q  <= sign_q;
									last_q      <= 1'b0;
									phase_q     <= P_DIG;
								end
							end else begin
								phase_q <= P_DIG;
							end
						end
						P_DIG: begin
							// digits were stored least significant first
							if (out_free) begin
								out_char_q  <= digit_char(dig_rd);
								last_q      <= (ndig_q == 4'd1) && (pad_q == '0);
								ndig_q      <= ndig_q - 4'd1;
								if (ndig_q == 4'd1) begin
									if (pad_q == '0) begin
										state_q <= S_IDLE;
									end else begin
										phase_q <= P_RPAD;
									end
								end
							end
						end
						P_RPAD: begin
							if (out_free) begin
								out_char_q  <= fill_q;
								last_q      <= (pad_q == WW'(1));
								pad_q       <= pad_q - 1'b1;
								if (pad_q == WW'(1)) begin
									state_q <= S_IDLE;
								end
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CONV))
		else $error("accepted item did not start conversion");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (ndig_q < 4'(DIG_MAX)))
		else $error("digit count overflow");

	a_digits_present: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && phase_q == P_DIG) |-> (ndig_q != '0))
		else $error("digit phase with no digits left");

	a_trail_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && phase_q == P_RPAD) |-> (left_q && pad_q != '0))
		else $error("trailing fill without left flag or count");

endmodule

// ===== tb/integer_to_ascii_formatter_test.sv =====
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;
	import ita_pkg::*;

	localparam int MAX_W      = MAX_FIELD_WIDTH_DEF;
	localparam int N_RANDOM   = 125;
	localparam int QUIET_MAX  = 2000;
	localparam int TAIL_WAIT  = 64;

	localparam logic [5:0] F_LEFT    = 6'b1 << FLAG_LEFT;
	localparam logic [5:0] F_SIGN    = 6'b1 << FLAG_SIGN;
	localparam logic [5:0] F_SPACE   = 6'b1 << FLAG_SPACE;
	localparam logic [5:0] F_PREFIX  = 6'b1 << FLAG_PREFIX;
	localparam logic [5:0] F_ZERO    = 6'b1 << FLAG_ZERO;
	localparam logic [5:0] F_SIGNINT = 6'b1 << FLAG_SIGNINT;

	typedef struct {
		logic [31:0] num;
		logic [5:0]  width;
		logic [1:0]  radix_sel;
		logic [5:0]  flags;
		string       text;	// empty: use the formatter model
	} field_req_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} field_char_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [31:0] value       = '0;
	logic [5:0]  field_width = '0;
	logic [1:0]  base_select = BASE_DEC;
	logic [5:0]  style_flags = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [7:0]  out_char;
	logic        last;

	field_char_t pending_chars[$];
	field_req_t  dir_tab[$];
	int          error_count = 0;
	int          n_fields    = 0;
	int          n_chars     = 0;
	int          quiet_cycles = 0;
	bit          tx_idle_on  = 1'b1;
	bit          rx_idle_on  = 1'b1;

	integer_to_ascii_formatter #(
		.MAX_FIELD_WIDTH(MAX_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.field_width(field_width),
		.base_select(base_select),
		.style_flags(style_flags),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.last       (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void queue_chars(input logic [7:0] txt[$]);
		field_char_t c;
		for (int i = 0; i < txt.size(); i++) begin
			c.ch  = txt[i];
			c.lst = (i == txt.size() - 1);
			pending_chars.push_back(c);
		end
	endfunction

	// builds the expected characters of one field
	function automatic void format_field(input logic [31:0] v, input logic [5:0] w,
			input logic [1:0] b, input logic [5:0] f);
		logic [31:0] mag;
		logic [7:0]  fill;
		logic [7:0]  sgn;
		logic [3:0]  d;
		logic [7:0]  digs[$];
		logic [7:0]  txt[$];
		int          radix;
		int          fw;
		int          npre;
		int          nsgn;
		int          pad;
		mag   = v;
		fw    = (w > MAX_W) ? MAX_W : int'(w);
		radix = (b == BASE_OCT) ? 8 : (b == BASE_HEX) ? 16 : 10;
		fill  = f[FLAG_ZERO] ? CH_ZERO : CH_SPACE;
		sgn   = 8'h00;
		if (radix == 10 && f[FLAG_SIGN]) begin
			if (v[31]) begin
				sgn = CH_MINUS;
				mag = -v;
			end else if (!f[FLAG_SIGNINT]) begin
				sgn = CH_PLUS;
			end
		end else if (radix == 10 && !v[31] && f[FLAG_SPACE]) begin
			sgn = CH_SPACE;
		end
		do begin
			d = 4'(mag % radix);
			digs.push_front((d < 4'd10) ? CH_ZERO + d : CH_A_OFS + d);
			mag = mag / radix;
		end while (mag != 0);
		npre = !f[FLAG_PREFIX] ? 0 : (radix == 16) ? 2 : (radix == 8) ? 1 : 0;
		nsgn = (sgn != 8'h00) ? 1 : 0;
		pad  = fw - npre - nsgn - digs.size();
		if (!f[FLAG_LEFT]) begin
			while (pad > 0) begin
				txt.push_back(fill);
				pad--;
			end
		end
		if (npre >= 1) txt.push_back(CH_ZERO);
		if (npre == 2) txt.push_back(CH_X);
		if (nsgn == 1) txt.push_back(sgn);
		foreach (digs[i]) txt.push_back(digs[i]);
		while (pad > 0) begin
			txt.push_back(fill);
			pad--;
		end
		queue_chars(txt);
	endfunction

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_field(input field_req_t r);
		logic [7:0] txt[$];
		if (tx_idle_on) begin
			while ($urandom_range(0, 99) < 19) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		value       <= r.num;
		field_width <= r.width;
		base_select <= r.radix_sel;
		style_flags <= r.flags;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (r.text.len() == 0) begin
			format_field(r.num, r.width, r.radix_sel, r.flags);
		end else begin
			for (int i = 0; i < r.text.len(); i++) txt.push_back(r.text[i]);
			queue_chars(txt);
		end
		n_fields++;
		@(negedge clk);
	endtask

	task automatic drain_fields();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(negedge clk);
	endtask

	function automatic void add_row(input logic [31:0] v, input logic [5:0] w,
			input logic [1:0] b, input logic [5:0] f, input string s);
		field_req_t r;
		r.num       = v;
		r.width     = w;
		r.radix_sel = b;
		r.flags     = f;
		r.text      = s;
		dir_tab.push_back(r);
	endfunction

	function automatic field_req_t random_field();
		field_req_t r;
		case ($urandom_range(0, 5))
			0: r.num = $urandom_range(0, 20);
			1: r.num = 32'h8000_0000 | $urandom_range(0, 50);
			2: r.num = -$urandom_range(1, 1000);
			3: r.num = 32'hFFFF_FFFF - $urandom_range(0, 20);
			default: r.num = $urandom;
		endcase
		if ($urandom_range(0, 99) < 80) begin
			r.width = 6'($urandom_range(0, 16));
		end else begin
			r.width = 6'($urandom_range(17, 63));
		end
		r.radix_sel = 2'($urandom_range(0, 3));
		r.flags     = 6'($urandom_range(0, 63));
		r.text      = "";
		return r;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= rx_idle_on && ($urandom_range(0, 99) < 19);
		end
	end

	always @(posedge clk) begin : char_check
		field_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_chars++;
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected char: expected none, got %h last %b",
					$time, out_char, last);
				error_count++;
			end else begin
				want = pending_chars.pop_front();
				if (out_char !== want.ch) begin
					$display("%0t: out_char: expected %h, got %h", $time, want.ch, out_char);
					error_count++;
				end
				if (last !== want.lst) begin
					$display("%0t: last: expected %b, got %b", $time, want.lst, last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_MAX) begin
				$display("%0t: timeout, %0d chars still outstanding", $time,
					pending_chars.size());
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		field_req_t r;

		add_row(32'h0,         6'd0,  BASE_HEX, F_PREFIX, "0x0");
		add_row(32'h0,         6'd0,  BASE_OCT, F_PREFIX, "00");
		add_row(32'h0,         6'd0,  BASE_DEC, 6'h00, "0");
		add_row(32'h8000_0000, 6'd0,  BASE_DEC, F_SIGN, "-2147483648");
		add_row(32'hFFFF_FFFF, 6'd0,  BASE_DEC, F_SIGN, "-1");
		add_row(32'hFFFF_FFFF, 6'd0,  BASE_DEC, 6'h00, "4294967295");
		add_row(32'hFFFF_FFFF, 6'd0,  BASE_HEX, 6'h00, "ffffffff");
		add_row(32'hFFFF_FFFF, 6'd0,  BASE_OCT, F_PREFIX, "037777777777");
		add_row(32'd5,         6'd0,  BASE_DEC, F_SIGN, "+5");
		add_row(32'd5,         6'd0,  BASE_DEC, F_SIGN | F_SIGNINT, "5");
		add_row(32'd5,         6'd0,  BASE_DEC, F_SPACE, " 5");
		// negative with space only: prints unsigned, no sign slot
		add_row(32'h8000_0005, 6'd0,  BASE_DEC, F_SPACE, "2147483653");
		add_row(32'd5,         6'd4,  BASE_DEC, 6'h00, "   5");
		add_row(32'd5,         6'd3,  BASE_DEC, F_LEFT | F_ZERO, "500");
		add_row(32'd5,         6'd3,  BASE_DEC, F_LEFT, "5  ");
		// leading fill goes ahead of the prefix
		add_row(32'h1F,        6'd6,  BASE_HEX, F_PREFIX | F_ZERO, "000x1f");
		add_row(32'd42,        6'd0,  2'd3, 6'h00, "42");
		add_row(32'd7,         6'd0,  BASE_HEX, F_SIGN | F_SPACE | F_SIGNINT, "7");
		add_row(32'd10,        6'd0,  BASE_DEC, F_PREFIX, "10");
		add_row(32'h7FFF_FFFF, 6'd12, BASE_DEC, F_SIGN | F_ZERO, "0+2147483647");
		add_row(32'd3,         6'd2,  BASE_DEC, 6'h3F, "30");
		add_row(32'hDEAD_BEEF, 6'd63, BASE_HEX, F_PREFIX, "");
		add_row(32'd1,         6'd32, BASE_OCT, F_LEFT | F_ZERO, "");
		add_row(32'h8000_0000, 6'd20, BASE_DEC, F_SIGN | F_LEFT, "");
		add_row(32'h1234_5678, 6'd33, BASE_DEC, F_ZERO | F_SPACE, "");

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) send_field(dir_tab[i]);
		drain_fields();
		@(negedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			// back-to-back stretch with both sides always ready
			tx_idle_on = !(i >= 50 && i < 90);
			rx_idle_on = tx_idle_on;
			if (i == 100) begin
				drain_fields();
				@(negedge clk);
			end
			r = random_field();
			send_field(r);
		end
		drain_fields();
		repeat (TAIL_WAIT) @(negedge clk);

		$display("Formatted %0d fields (%0d chars) in octal, decimal and hex,",
			n_fields, n_chars);
		$display("covering sign, space, prefix, zero fill, left justify and width limits");
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
